// ===== rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// Shared constants, types and a helper function for the ack range tracker.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int MaxRanges = 32;
	localparam int IdxW      = $clog2(MaxRanges);
	localparam int CntW      = 6;
	localparam int PnW       = 62;
	localparam int EncW      = 10;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_PRUNE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_NEW     = 2'd0;
	localparam logic [1:0] ST_EXTEND  = 2'd1;
	localparam logic [1:0] ST_COVERED = 2'd2;
	localparam logic [1:0] ST_OTHER   = 2'd3;

	// datapath commands
	typedef struct packed {
		logic load;       // capture the input item
		logic clear;      // empty the table
		logic find_step;  // lookup: test entry at find index
		logic add_apply;  // apply add decision
		logic merge_step; // merge one neighbor
		logic prune_step; // one prune step
		logic enc_init;   // start size sum
		logic enc_step;   // add one gap term
		logic enc_done;   // store the size
	} art_cmd_t;

	typedef struct packed {
		logic find_done;
		logic merge_done;
		logic prune_done;
		logic enc_last;
		logic [1:0] status;
	} art_sts_t;

	function automatic logic [3:0] vsize(input logic [PnW-1:0] v);
		if (v[PnW-1:6] == '0) return 4'd1;
		else if (v[PnW-1:14] == '0) return 4'd2;
		else if (v[PnW-1:30] == '0) return 4'd4;
		else return 4'd8;
	endfunction

endpackage

// ===== rtl/art_datapath.sv =====
// ----------------------------------------------------------------------------
// art_datapath
// Range table registers, lookup, shift and merge logic and size accumulator.
// ----------------------------------------------------------------------------
module art_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  art_pkg::art_cmd_t         cmd,
	output art_pkg::art_sts_t         sts,
	input  logic [art_pkg::PnW-1:0]   range_first,
	input  logic [art_pkg::PnW-1:0]   range_last,
	input  logic [art_pkg::PnW-1:0]   largest_acked,
	output logic [art_pkg::CntW-1:0]  count_o,
	output logic [art_pkg::EncW-1:0]  enc_o
);
	localparam int N = art_pkg::MaxRanges;
	localparam int PW = art_pkg::PnW;
	localparam int IW = art_pkg::IdxW;

	// table entries shift as a row, so each entry is its own register
	logic [PW-1:0] low_q  [N];
	logic [PW-1:0] high_q [N];
	logic [art_pkg::CntW-1:0] count_q;
	logic [art_pkg::EncW-1:0] enc_q;

	logic [PW-1:0] lo_q, hi_q, la_q;
	logic [art_pkg::CntW-1:0] fidx_q;   // lookup index
	logic          found_q;
	logic [IW-1:0] pidx_q;   // last entry with low <= lo
	logic [IW-1:0] midx_q;   // merge position
	logic [1:0]    status_q;
	logic [IW-1:0] eidx_q;   // size walk index
	logic [11:0]   sum_q;

	logic [IW-1:0] fi;
	assign fi = fidx_q[IW-1:0];

	// insert position after optional eviction
	logic full;
	logic [IW-1:0] ins_p;
	logic [art_pkg::CntW-1:0] cnt_m1;
	assign full   = count_q >= art_pkg::CntW'(N);
	assign cnt_m1 = count_q - 1'b1;
	assign ins_p  = found_q ? (full ? pidx_q : pidx_q + 1'b1) : '0;

	logic [IW:0] mnext;
	assign mnext = {1'b0, midx_q} + 1'b1;
	logic can_merge;
	// one extra bit so a range ending at the top number still touches
	assign can_merge = ({1'b0, mnext} < {1'b0, count_q})
		&& ({1'b0, high_q[midx_q]} + 1'b1 >= {1'b0, low_q[mnext[IW-1:0]]});

	logic [IW-1:0] ei_m1;
	assign ei_m1 = eidx_q - 1'b1;

	logic [PW-1:0] top_hi, top_lo;
	assign top_hi = high_q[cnt_m1[IW-1:0]];
	assign top_lo = low_q[cnt_m1[IW-1:0]];

	always_comb begin
		sts.find_done  = (fidx_q >= count_q) || (low_q[fi] > lo_q);
		sts.merge_done = !can_merge;
		sts.prune_done = (count_q == '0) || (low_q[0] > la_q)
			|| (la_q < high_q[0]) || (count_q == art_pkg::CntW'(1));
		sts.enc_last   = (eidx_q == '0);
		sts.status     = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			enc_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				enc_q   <= '0;
			end
			if (cmd.add_apply && !(found_q && high_q[pidx_q] >= hi_q)
				&& !(found_q && high_q[pidx_q] + 1'b1 >= lo_q) && !full)
				count_q <= count_q + 1'b1;
			if (cmd.merge_step && can_merge)
				count_q <= count_q - 1'b1;
			if (cmd.prune_step && !sts.prune_done)
				count_q <= count_q - 1'b1;
			if (cmd.enc_done && count_q != '0)
				enc_q <= (sum_q > 12'd1023) ? '1 : sum_q[art_pkg::EncW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q    <= range_first;
			hi_q    <= (range_last < range_first) ? range_first : range_last;
			la_q    <= largest_acked;
			fidx_q  <= '0;
			found_q <= 1'b0;
			pidx_q  <= '0;
			status_q <= art_pkg::ST_OTHER;
		end
		if (cmd.find_step && !sts.find_done) begin
			found_q <= 1'b1;
			pidx_q  <= fi;
			fidx_q  <= fidx_q + 1'b1;
		end
		if (cmd.add_apply) begin
			if (found_q && high_q[pidx_q] >= hi_q) begin
				status_q <= art_pkg::ST_COVERED;
				midx_q   <= pidx_q;
			end else if (found_q && high_q[pidx_q] + 1'b1 >= lo_q) begin
				status_q <= art_pkg::ST_EXTEND;
				high_q[pidx_q] <= hi_q;
				midx_q   <= pidx_q;
			end else begin
				status_q <= art_pkg::ST_NEW;
				midx_q   <= ins_p;
				// evict lowest when full, then open a slot at ins_p
				for (int i = 0; i < N; i++) begin
					if (full) begin
						if (IW'(i) < ins_p) begin
							if (i + 1 < N) begin
								low_q[i]  <= low_q[i+1];
								high_q[i] <= high_q[i+1];
							end
						end
					end else if (IW'(i) > ins_p && i > 0) begin
						low_q[i]  <= low_q[i-1];
						high_q[i] <= high_q[i-1];
					end
				end
				low_q[ins_p]  <= lo_q;
				high_q[ins_p] <= hi_q;
			end
		end
		if (cmd.merge_step && can_merge) begin
			if (high_q[mnext[IW-1:0]] > high_q[midx_q])
				high_q[midx_q] <= high_q[mnext[IW-1:0]];
			for (int i = 0; i < N; i++) begin
				if (IW'(i) > midx_q && i + 1 < N) begin
					low_q[i]  <= low_q[i+1];
					high_q[i] <= high_q[i+1];
				end
			end
		end
		if (cmd.prune_step && count_q != '0 && !(low_q[0] > la_q)) begin
			if (la_q < high_q[0]) begin
				low_q[0] <= la_q + 1'b1;
			end else if (count_q != art_pkg::CntW'(1)) begin
				for (int i = 0; i + 1 < N; i++) begin
					low_q[i]  <= low_q[i+1];
					high_q[i] <= high_q[i+1];
				end
			end
		end
		if (cmd.enc_init) begin
			eidx_q <= cnt_m1[IW-1:0];
			sum_q  <= 12'(art_pkg::vsize(top_hi)) + 12'(art_pkg::vsize(top_hi - top_lo))
				+ 12'(art_pkg::vsize(PW'(cnt_m1)));
		end
		if (cmd.enc_step && eidx_q != '0) begin
			eidx_q <= ei_m1;
			sum_q  <= sum_q
				+ 12'(art_pkg::vsize(low_q[eidx_q] - high_q[ei_m1] - PW'(2)))
				+ 12'(art_pkg::vsize(high_q[ei_m1] - low_q[ei_m1]));
		end
	end

	assign count_o = count_q;
	assign enc_o   = enc_q;
endmodule

// ===== rtl/art_ctrl.sv =====
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer for lookup, insert, merge, prune and size walk.
// ----------------------------------------------------------------------------
module art_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  art_pkg::art_sts_t sts,
	output art_pkg::art_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIND  = 3'd1;
	localparam logic [2:0] S_APPLY = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_EINIT = 3'd4;
	localparam logic [2:0] S_ESUM  = 3'd5;
	localparam logic [2:0] S_PRUNE = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (opcode)
						art_pkg::OP_ADD:   state_d = S_FIND;
						art_pkg::OP_PRUNE: state_d = S_PRUNE;
						art_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
							state_d = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_FIND: begin
				cmd.find_step = 1'b1;
				if (sts.find_done) state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.add_apply = 1'b1;
				state_d = S_MERGE;
			end
			S_MERGE: begin
				cmd.merge_step = 1'b1;
				if (sts.merge_done) state_d = S_EINIT;
			end
			S_EINIT: begin
				cmd.enc_init = 1'b1;
				state_d = S_ESUM;
			end
			S_ESUM: begin
				cmd.enc_step = 1'b1;
				if (sts.enc_last) begin
					cmd.enc_done = 1'b1;
					state_d = S_DONE;
				end
			end
			S_PRUNE: begin
				cmd.prune_step = 1'b1;
				if (sts.prune_done) state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
endmodule

// ===== rtl/ack_range_tracker.sv =====
// ----------------------------------------------------------------------------
// ack_range_tracker
// Sorted table of received packet-number ranges with ACK frame size.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the start transfer until the result
// strobe. An add runs the lookup walk, one apply step, the merge walk and the
// size walk, then the done state; a prune trims or drops ranges at the low end
// of the table and then goes to done; clear and unused codes go straight to
// done. The result is on status, range_count and encoded_size for the single
// cycle that valid is high; the receiver cannot stall it.
module ack_range_tracker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic [art_pkg::PnW-1:0]   range_first,
	input  logic [art_pkg::PnW-1:0]   range_last,
	input  logic [art_pkg::PnW-1:0]   largest_acked,
	output logic                      valid,
	output logic [1:0]                status,
	output logic [art_pkg::CntW-1:0]  range_count,
	output logic [art_pkg::EncW-1:0]  encoded_size
);
	art_pkg::art_cmd_t cmd;
	art_pkg::art_sts_t sts;

	art_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.sts(sts), .cmd(cmd), .busy(busy), .done(valid)
	);

	art_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.range_first(range_first), .range_last(range_last),
		.largest_acked(largest_acked), .count_o(range_count),
		.enc_o(encoded_size)
	);

	assign status = sts.status;

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy) else $error("result strobe while not busy");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("result strobe longer than one cycle");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		range_count <= art_pkg::CntW'(art_pkg::MaxRanges))
		else $error("range count above table size");
endmodule
